@@ rtl/rdq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared constants and types of the restricted deque: sizes, operation and
// status codes, and the control word broadcast to the row of cells.
// ----------------------------------------------------------------------------
package rdq_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_END   = 3'd3;
   localparam logic [OP_W-1:0] OP_LIST      = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_DENIED = 2'd3;

   localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
   localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_PUSH_FRONT,
      CMD_PUSH_BACK,
      CMD_POP_FRONT,
      CMD_ROTATE
   } cmd_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [IDX_W-1:0] push_idx;
      logic [IDX_W-1:0] tail_idx;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/rdq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_cell
// One storage cell of the deque row. Loads a new value, takes its left or
// right neighbor's entry or the front entry, or holds, as the broadcast command says.
// ----------------------------------------------------------------------------
module rdq_cell (
   input  wire logic                          clock,
   input  wire rdq_pkg::cell_ctrl_type        ctrl,
   input  wire logic [rdq_pkg::IDX_W-1:0]     cell_idx,
   input  wire logic signed [rdq_pkg::DATA_W-1:0] new_value,
   input  wire logic signed [rdq_pkg::DATA_W-1:0] prev_q,
   input  wire logic signed [rdq_pkg::DATA_W-1:0] next_q,
   input  wire logic signed [rdq_pkg::DATA_W-1:0] head_q,
   output logic signed [rdq_pkg::DATA_W-1:0]      q
);
   import rdq_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.cmd)
         CMD_PUSH_FRONT: begin
            entry_in = (cell_idx == '0) ? new_value : prev_q;
         end
         CMD_PUSH_BACK: begin
            if (cell_idx == ctrl.push_idx) begin
               entry_in = new_value;
            end
         end
         CMD_POP_FRONT: begin
            entry_in = next_q;
         end
         CMD_ROTATE: begin
            entry_in = (cell_idx == ctrl.tail_idx) ? head_q : next_q;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule
`default_nettype wire

@@ rtl/rdq_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_chain
// Row of DEPTH cells holding the deque front to back, cell 0 at the front.
// Presents the front entry and the entry at the tail index.
// ----------------------------------------------------------------------------
module rdq_chain (
   input  wire logic                              clock,
   input  wire rdq_pkg::cell_ctrl_type            ctrl,
   input  wire logic signed [rdq_pkg::DATA_W-1:0] new_value,
   output logic signed [rdq_pkg::DATA_W-1:0]      head_q,
   output logic signed [rdq_pkg::DATA_W-1:0]      tail_q
);
   import rdq_pkg::*;

   logic signed [DATA_W-1:0] cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_d;
      logic signed [DATA_W-1:0] next_d;

      if (i == 0) begin : g_first
         assign prev_d = new_value;
      end else begin : g_mid_prev
         assign prev_d = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_d = cell_q[i];
      end else begin : g_mid_next
         assign next_d = cell_q[i+1];
      end

      rdq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .cell_idx  (IDX_W'(i)),
         .new_value (new_value),
         .prev_q    (prev_d),
         .next_q    (next_d),
         .head_q    (cell_q[0]),
         .q         (cell_q[i])
      );
   end

   assign head_q = cell_q[0];
   assign tail_q = cell_q[ctrl.tail_idx];

endmodule
`default_nettype wire

@@ rtl/restricted_deque.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// restricted_deque
// Double-ended queue of signed 32-bit entries, restricted by mode.
// ----------------------------------------------------------------------------
// Requests arrive on req_ (op, value) and results leave on rsp_ (data,
// status, last); both channels use valid/stall. csr_wr_en/csr_wr_data set
// the mode: 0 input-restricted, 1 output-restricted.
// Every request yields its first result in the output register at the clock
// edge that accepts it. Inserts, deletes and refused requests give one result
// each and complete at one item per cycle while rsp_stall is low. A list of N
// entries streams N results, one per cycle while rsp_stall is low, front to
// back, with last on the final one; the row of cells rotates one place per
// result, and new requests wait until the list is done.
// While rsp_stall is high the held result stays put and req_stall is raised;
// nothing is lost. Reset empties the deque and clears the mode to 0; entry
// contents are not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module restricted_deque (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [rdq_pkg::OP_W-1:0]          req_op,
   input  wire logic signed [rdq_pkg::DATA_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [rdq_pkg::DATA_W-1:0]      rsp_data,
   output logic [rdq_pkg::STAT_W-1:0]             rsp_status,
   output logic                                   rsp_last,
   input  wire logic                              csr_wr_en,
   input  wire logic                              csr_wr_data
);
   import rdq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic                     mode_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] head_q;
   logic signed [DATA_W-1:0] tail_q;
   logic                     out_free;
   logic                     req_accept;
   logic                     allowed;
   logic                     is_empty;
   logic                     is_full;
   logic [CNT_W-1:0]         count_m1;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign count_m1   = count_ff - CNT_W'(1);

   always_comb begin
      case (req_op)
         OP_LIST:      allowed = 1'b1;
         OP_INS_END:   allowed = 1'b1;
         OP_DEL_END:   allowed = 1'b1;
         OP_INS_FRONT: allowed = (mode_ff == MODE_OUTPUT_RESTRICTED);
         OP_DEL_FRONT: allowed = (mode_ff == MODE_INPUT_RESTRICTED);
         default:      allowed = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl.cmd      = CMD_HOLD;
      ctrl.push_idx = count_ff[IDX_W-1:0];
      ctrl.tail_idx = count_m1[IDX_W-1:0];

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff == S_LIST) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = head_q;
            rsp_status_in = STAT_OK;
            rsp_last_in   = (left_ff == CNT_W'(1));
            ctrl.cmd      = CMD_ROTATE;
            left_in       = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
      end else if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = STAT_OK;
         rsp_last_in   = 1'b1;
         if (!allowed) begin
            rsp_status_in = STAT_DENIED;
         end else begin
            case (req_op)
               OP_INS_FRONT, OP_INS_END: begin
                  if (is_full) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     ctrl.cmd = (req_op == OP_INS_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_DEL_FRONT: begin
                  if (is_empty) begin
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     rsp_data_in = head_q;
                     ctrl.cmd    = CMD_POP_FRONT;
                     count_in    = count_m1;
                  end
               end
               OP_DEL_END: begin
                  if (is_empty) begin
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     rsp_data_in = tail_q;
                     count_in    = count_m1;
                  end
               end
               default: begin
                  if (is_empty) begin
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     rsp_data_in = head_q;
                     ctrl.cmd    = CMD_ROTATE;
                     rsp_last_in = (count_ff == CNT_W'(1));
                     left_in     = count_m1;
                     if (count_ff != CNT_W'(1)) begin
                        state_in = S_LIST;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         mode_ff      <= MODE_INPUT_RESTRICTED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   rdq_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .new_value (req_value),
      .head_q    (head_q),
      .tail_q    (tail_q)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the restricted deque: a short directed table
// (empty, refused, extreme and unused-op requests in both modes), then
// random insert/delete/list traffic that steers the deque toward full and back
// toward empty, run under four sender/receiver idling patterns. Every result is
// checked field by field against an in-bench model of the ring.
// ----------------------------------------------------------------------------
module tb_top;
   import rdq_pkg::*;

   localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int PHASE_ITEMS  = 50;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STAT_W-1:0]        status;
      logic                     last;
   } reply_type;

   typedef struct packed {
      logic              set_mode;
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
      logic              typed;
      logic [STAT_W-1:0] status;
   } step_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [OP_W-1:0]            req_op;
   logic signed [DATA_W-1:0]   req_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [DATA_W-1:0]   rsp_data;
   logic [STAT_W-1:0]          rsp_status;
   logic                       rsp_last;
   logic                       csr_wr_en;
   logic                       csr_wr_data;

   // deque model
   logic signed [DATA_W-1:0]   held_entries [DEPTH];
   logic [IDX_W-1:0]           front_pos = '0;
   logic [CNT_W-1:0]           held_count = '0;
   logic                       mode_now = MODE_INPUT_RESTRICTED;

   reply_type                  replies_due [$];
   int                         mismatches = 0;
   int                         cycles = 0;
   int                         idle_pct = 0;
   int                         stall_pct = 0;

   restricted_deque DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic predict_deque(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
      reply_type        r;
      logic             allowed;
      logic [IDX_W-1:0] pos;
      allowed = (op == OP_LIST) || (op == OP_INS_END) || (op == OP_DEL_END) ||
                (mode_now == MODE_INPUT_RESTRICTED ? op == OP_DEL_FRONT : op == OP_INS_FRONT);
      r.data   = '0;
      r.status = STAT_OK;
      r.last   = 1'b1;
      if (!allowed) begin
         r.status = STAT_DENIED;
      end else if (op == OP_INS_FRONT || op == OP_INS_END) begin
         if (held_count == DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            if (op == OP_INS_FRONT) begin
               front_pos = front_pos - 1'b1;
               pos = front_pos;
            end else begin
               pos = front_pos + held_count[IDX_W-1:0];
            end
            held_entries[pos] = value;
            held_count++;
         end
      end else if (held_count == 0) begin
         r.status = STAT_EMPTY;
      end else if (op == OP_DEL_FRONT) begin
         r.data = held_entries[front_pos];
         front_pos = front_pos + 1'b1;
         held_count--;
      end else if (op == OP_DEL_END) begin
         pos = front_pos + held_count[IDX_W-1:0] - 1'b1;
         r.data = held_entries[pos];
         held_count--;
      end else begin
         for (int i = 0; i < held_count - 1; i++) begin
            pos = front_pos + i[IDX_W-1:0];
            replies_due.push_back('{held_entries[pos], STAT_OK, 1'b0});
         end
         pos = front_pos + held_count[IDX_W-1:0] - 1'b1;
         r.data = held_entries[pos];
      end
      replies_due.push_back(r);
   endtask

   // called and returns at a falling edge; valid stays high for back-to-back items
   task automatic send_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_deque(op, value);
      @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      mode_now = m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic step_type plan_step(input logic set_mode, input logic [OP_W-1:0] op,
                                          input logic [DATA_W-1:0] value, input logic typed,
                                          input logic [STAT_W-1:0] status);
      plan_step = '{set_mode, op, value, typed, status};
   endfunction

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      reply_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got data %0d status %0d last %0d",
                     $time, rsp_data, rsp_status, rsp_last);
            mismatches++;
         end else begin
            due = replies_due.pop_front();
            if (rsp_data !== due.data) begin
               $display("%0t: rsp_data expected %0d, got %0d", $time, due.data, rsp_data);
               mismatches++;
            end
            if (rsp_status !== due.status) begin
               $display("%0t: rsp_status expected %0d, got %0d", $time, due.status, rsp_status);
               mismatches++;
            end
            if (rsp_last !== due.last) begin
               $display("%0t: rsp_last expected %0d, got %0d", $time, due.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      step_type          plan [$];
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
      logic              growing;
      int                pick;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_op      = '0;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      growing     = 1'b1;

      plan.push_back(plan_step(1'b0, OP_LIST,      32'h0,         1'b1, STAT_EMPTY));
      plan.push_back(plan_step(1'b0, OP_DEL_FRONT, 32'h0,         1'b1, STAT_EMPTY));
      plan.push_back(plan_step(1'b0, OP_DEL_END,   32'h0,         1'b1, STAT_EMPTY));
      plan.push_back(plan_step(1'b0, OP_INS_FRONT, 32'h1234_5678, 1'b1, STAT_DENIED));
      plan.push_back(plan_step(1'b0, OP_RSVD_5,    32'h0,         1'b1, STAT_DENIED));
      plan.push_back(plan_step(1'b0, OP_RSVD_6,    32'h0,         1'b1, STAT_DENIED));
      plan.push_back(plan_step(1'b0, OP_RSVD_7,    32'hFFFF_FFFF, 1'b1, STAT_DENIED));
      plan.push_back(plan_step(1'b0, OP_INS_END,   32'h7FFF_FFFF, 1'b1, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_INS_END,   32'h8000_0000, 1'b1, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_INS_END,   32'hFFFF_FFFF, 1'b1, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_INS_END,   32'h0,         1'b1, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_LIST,      32'h0,         1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_DEL_FRONT, 32'h0,         1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_DEL_END,   32'h0,         1'b0, STAT_OK));
      plan.push_back(plan_step(1'b1, OP_INS_FRONT, 32'(MODE_OUTPUT_RESTRICTED), 1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_DEL_FRONT, 32'h0,         1'b1, STAT_DENIED));
      // front insert at position zero wraps the ring
      plan.push_back(plan_step(1'b0, OP_INS_FRONT, 32'h5555_5555, 1'b1, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_INS_FRONT, 32'hAAAA_AAAA, 1'b1, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_LIST,      32'h0,         1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_DEL_END,   32'h0,         1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_DEL_END,   32'h0,         1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_DEL_END,   32'h0,         1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_DEL_END,   32'h0,         1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_LIST,      32'h0,         1'b1, STAT_EMPTY));
      plan.push_back(plan_step(1'b1, OP_INS_FRONT, 32'(MODE_INPUT_RESTRICTED), 1'b0, STAT_OK));
      plan.push_back(plan_step(1'b0, OP_INS_FRONT, 32'h0,         1'b1, STAT_DENIED));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].set_mode) begin
            write_mode(plan[k].value[0]);
         end else begin
            send_req(plan[k].op, plan[k].value);
            if (plan[k].typed) begin
               void'(replies_due.pop_back());
               replies_due.push_back('{'0, plan[k].status, 1'b1});
            end
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         write_mode(ph % 2 == 1 ? MODE_OUTPUT_RESTRICTED : MODE_INPUT_RESTRICTED);
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               op = OP_W'($urandom_range(0, 7));
            end else if (pick < 14) begin
               op = OP_LIST;
            end else if (growing ? pick < 88 : pick < 30) begin
               if (mode_now == MODE_OUTPUT_RESTRICTED && $urandom_range(0, 1))
                  op = OP_INS_FRONT;
               else
                  op = OP_INS_END;
            end else begin
               if (mode_now == MODE_INPUT_RESTRICTED && $urandom_range(0, 1))
                  op = OP_DEL_FRONT;
               else
                  op = OP_DEL_END;
            end
            case ($urandom_range(0, 9))
               0: value = 32'h7FFF_FFFF;
               1: value = 32'h8000_0000;
               2: value = 32'hFFFF_FFFF;
               3: value = '0;
               default: value = $urandom();
            endcase
            send_req(op, value);
            // linger at full and at empty for a few items before turning around
            if (growing && held_count == DEPTH && $urandom_range(0, 3) == 0)
               growing = 1'b0;
            else if (!growing && held_count == 0 && $urandom_range(0, 2) == 0)
               growing = 1'b1;
         end
      end

      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rdq_pkg.sv
rtl/rdq_cell.sv
rtl/rdq_chain.sv
rtl/restricted_deque.sv
test/tb_top.sv
